@@ hw/rtl/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
// Request codes, result status codes and the command word broadcast to every storage cell.
// No dependencies.
package deq_pkg;

  localparam int unsigned DATA_W = 32;

  // Request codes carried on the input tuser
  typedef enum logic [1:0] {
    REQ_PUSH_BACK  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // What every cell of a chain does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_SHIFT_UP   = 2'd1,  // take the lower neighbor's value
    CELL_SHIFT_DOWN = 2'd2,  // take the upper neighbor's value
    CELL_LOAD       = 2'd3   // cell whose index equals the count loads the value
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [DATA_W-1:0]   value;
  } cell_cmd_t;

endpackage

@@ hw/rtl/double_ended_queue_top.sv @@
// Double-ended queue of DEPTH signed 32-bit values built from two rows of shifting cells.
// Depends on deq_pkg and deq_chain.

// One request is taken per cycle while results are taken; its result appears on the
// next cycle and sits in an output register until taken, while the next request may be
// accepted in that same cycle. Every request gives one result: a status, the front and
// back values after the step (zero when empty), and empty and full flags. A push into a
// full deque or a pop from an empty one leaves the contents unchanged and is flagged in
// the status. Storage is two rows of DEPTH cells: one row keeps the front value in its
// first cell, the other keeps the back value there, so both ends are read straight from
// a cell and every update is a shift of the row or a load into the cell at the count.
module double_ended_queue_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] push_value
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // [1:0] status, [33:2] front_value, [65:34] back_value,
                                 // [66] empty flag, [67] full flag, [71:68] zero
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  deq_pkg::req_t       req;
  deq_pkg::cell_cmd_t  front_cmd;
  deq_pkg::cell_cmd_t  back_cmd;
  deq_pkg::status_t    status_q;
  deq_pkg::status_t    status_next;

  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;
  logic                        accept;
  logic                        is_push;
  logic                        ok;
  logic                        empty_q;
  logic                        full_q;
  logic [deq_pkg::DATA_W-1:0]  front_head;
  logic [deq_pkg::DATA_W-1:0]  back_head;

  // Handshake: the output register frees up when its result is taken
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign req      = deq_pkg::req_t'(s_tuser);
  assign is_push  = (req == deq_pkg::REQ_PUSH_BACK) || (req == deq_pkg::REQ_PUSH_FRONT);
  assign ok       = is_push ? (count != CNT_W'(DEPTH)) : (count != '0);

  // Commands for both rows and the new count
  always_comb begin
    front_cmd.value = s_tdata;
    back_cmd.value  = s_tdata;
    front_cmd.op    = deq_pkg::CELL_HOLD;
    back_cmd.op     = deq_pkg::CELL_HOLD;
    count_next      = count;
    if (accept && ok) begin
      unique case (req)
        deq_pkg::REQ_PUSH_BACK: begin
          front_cmd.op = deq_pkg::CELL_LOAD;
          back_cmd.op  = deq_pkg::CELL_SHIFT_UP;
          count_next   = count + 1'b1;
        end
        deq_pkg::REQ_PUSH_FRONT: begin
          front_cmd.op = deq_pkg::CELL_SHIFT_UP;
          back_cmd.op  = deq_pkg::CELL_LOAD;
          count_next   = count + 1'b1;
        end
        deq_pkg::REQ_POP_FRONT: begin
          front_cmd.op = deq_pkg::CELL_SHIFT_DOWN;
          count_next   = count - 1'b1;
        end
        deq_pkg::REQ_POP_BACK: begin
          back_cmd.op  = deq_pkg::CELL_SHIFT_DOWN;
          count_next   = count - 1'b1;
        end
        default: count_next = count;
      endcase
    end
  end

  // Status of this request
  always_comb begin
    if (ok) begin
      status_next = deq_pkg::ST_DONE;
    end else if (is_push) begin
      status_next = deq_pkg::ST_FULL;
    end else begin
      status_next = deq_pkg::ST_EMPTY;
    end
  end

  deq_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_front_chain (
    .clk   (clk),
    .cmd   (front_cmd),
    .count (count),
    .head  (front_head)
  );

  deq_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_back_chain (
    .clk   (clk),
    .cmd   (back_cmd),
    .count (count),
    .head  (back_head)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result flags; the cells hold still while a result waits
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
      empty_q  <= (count_next == '0);
      full_q   <= (count_next == CNT_W'(DEPTH));
    end
  end

  assign m_tdata = {4'b0000, full_q, empty_q,
                    (empty_q ? '0 : back_head),
                    (empty_q ? '0 : front_head),
                    status_q};

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("deque count above depth");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    accept && is_push && (count == CNT_W'(DEPTH))
      |=> m_tvalid && (status_q == deq_pkg::ST_FULL) && full_q && $stable(count))
    else $error("push into full deque not rejected");

  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    accept && is_push && (count != CNT_W'(DEPTH))
      |=> !empty_q && (count == $past(count) + 1'b1))
    else $error("accepted push did not grow the deque");

endmodule

@@ hw/rtl/deq_cell.sv @@
// One storage cell of a deque chain: holds one value and trades it with its neighbors.
// Depends on deq_pkg for the command word.
module deq_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                         clk,
  input  deq_pkg::cell_cmd_t           cmd,
  input  logic [CNT_W-1:0]             count,
  input  logic [deq_pkg::DATA_W-1:0]   lower_data,
  input  logic [deq_pkg::DATA_W-1:0]   upper_data,
  output logic [deq_pkg::DATA_W-1:0]   data
);

  logic [deq_pkg::DATA_W-1:0] data_next;

  // Local decision from the broadcast command
  always_comb begin
    data_next = data;
    unique case (cmd.op)
      deq_pkg::CELL_HOLD:       data_next = data;
      deq_pkg::CELL_SHIFT_UP:   data_next = lower_data;
      deq_pkg::CELL_SHIFT_DOWN: data_next = upper_data;
      deq_pkg::CELL_LOAD: begin
        if (count == CNT_W'(IDX)) data_next = cmd.value;
      end
      default:                  data_next = data;
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

@@ hw/rtl/deq_chain.sv @@
// Row of DEPTH deque cells; cell 0 holds the value at one end of the deque.
// Depends on deq_pkg and deq_cell.
module deq_chain #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CNT_W = 5
) (
  input  logic                         clk,
  input  deq_pkg::cell_cmd_t           cmd,
  input  logic [CNT_W-1:0]             count,
  output logic [deq_pkg::DATA_W-1:0]   head
);

  logic [deq_pkg::DATA_W-1:0] cell_data [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [deq_pkg::DATA_W-1:0] lower_in;
      logic [deq_pkg::DATA_W-1:0] upper_in;

      // Ends of the row: new value enters at cell 0, last cell keeps its own value
      if (i == 0) begin : g_first
        assign lower_in = cmd.value;
      end else begin : g_mid_lo
        assign lower_in = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign upper_in = cell_data[i];
      end else begin : g_mid_hi
        assign upper_in = cell_data[i+1];
      end

      deq_cell #(
        .IDX   (i),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .count      (count),
        .lower_data (lower_in),
        .upper_data (upper_in),
        .data       (cell_data[i])
      );
    end
  endgenerate

  assign head = cell_data[0];

endmodule

@@ test/double_ended_queue_top_test.sv @@
// Testbench for double_ended_queue_top: directed edge cases, then a long random walk.
// Depends on deq_pkg and the RTL of double_ended_queue_top; checks every result against
// a local deque predictor.
`timescale 1ns / 100ps

module double_ended_queue_top_test;

  localparam int unsigned DQ_DEPTH   = 16;
  localparam int unsigned STALL_PCT  = 8;
  localparam int unsigned WDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT = 4;
  localparam int unsigned MAX_REPORT = 10;
  localparam int unsigned PEND_DEPTH = 8;

  // Expected result, packed so that the low 68 bits line up with m_tdata
  typedef struct packed {
    logic               full_flag;
    logic               empty_flag;
    logic [31:0]        back_value;
    logic [31:0]        front_value;
    deq_pkg::status_t   status;
  } deq_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] push_value
  logic [1:0]  s_tuser = '0;   // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // [1:0] status, [33:2] front, [65:34] back, [66] empty,
                               // [67] full, [71:68] zero

  // Predictor state: ring of held values, and a FIFO of expected results
  logic [31:0] model_store [DQ_DEPTH];
  int unsigned model_head = 0;
  int unsigned model_count = 0;
  deq_result_t pend_store [PEND_DEPTH];
  int unsigned pend_wr = 0;
  int unsigned pend_rd = 0;

  // Bookkeeping
  logic        gaps_on = 1'b1;
  int unsigned mismatch_count = 0;
  int unsigned request_count = 0;
  int unsigned full_rejects = 0;
  int unsigned empty_rejects = 0;
  int unsigned full_reached = 0;
  int unsigned quiet_cycles = 0;

  double_ended_queue_top #(.DEPTH(DQ_DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one request to the predicted deque and return the result it should give
  function automatic deq_result_t next_deque_result(deq_pkg::req_t kind, logic [31:0] value);
    deq_result_t res;
    res.status = deq_pkg::ST_DONE;
    case (kind)
      deq_pkg::REQ_PUSH_BACK, deq_pkg::REQ_PUSH_FRONT: begin
        if (model_count >= DQ_DEPTH) begin
          res.status = deq_pkg::ST_FULL;
        end else if (kind == deq_pkg::REQ_PUSH_BACK) begin
          model_store[(model_head + model_count) % DQ_DEPTH] = value;
          model_count++;
        end else begin
          model_head = (model_head + DQ_DEPTH - 1) % DQ_DEPTH;
          model_store[model_head] = value;
          model_count++;
        end
      end
      default: begin
        if (model_count == 0) begin
          res.status = deq_pkg::ST_EMPTY;
        end else if (kind == deq_pkg::REQ_POP_FRONT) begin
          model_head = (model_head + 1) % DQ_DEPTH;
          model_count--;
        end else begin
          model_count--;
        end
      end
    endcase
    res.empty_flag = (model_count == 0);
    res.full_flag  = (model_count >= DQ_DEPTH);
    if (model_count == 0) begin
      res.front_value = '0;
      res.back_value  = '0;
    end else begin
      res.front_value = model_store[model_head];
      res.back_value  = model_store[(model_head + model_count - 1) % DQ_DEPTH];
    end
    return res;
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORT) begin
      $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    end
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      note_mismatch(what, want, got);
    end
  endfunction

  // Present one request, with random gaps ahead of it, and record its expected result
  task automatic issue_request(deq_pkg::req_t kind, logic [31:0] value);
    deq_result_t res;
    while (gaps_on && $urandom_range(99) < STALL_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    res = next_deque_result(kind, value);
    pend_store[pend_wr % PEND_DEPTH] = res;
    pend_wr++;
    request_count++;
    if (res.status == deq_pkg::ST_FULL) begin
      full_rejects++;
    end
    if (res.status == deq_pkg::ST_EMPTY) begin
      empty_rejects++;
    end
    if (res.full_flag) begin
      full_reached++;
    end
  endtask

  // Pops on an empty deque, and pops that remove the only value
  task automatic test_empty_edges();
    issue_request(deq_pkg::REQ_POP_FRONT, 32'h0000_0000);
    issue_request(deq_pkg::REQ_POP_BACK, 32'hFFFF_FFFF);
    issue_request(deq_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
    issue_request(deq_pkg::REQ_POP_BACK, 32'h1234_5678);
    issue_request(deq_pkg::REQ_PUSH_BACK, 32'h7FFF_FFFF);
    issue_request(deq_pkg::REQ_POP_FRONT, 32'h0);
  endtask

  // Fill from both ends, first with extreme values and then random ones, then push into the full deque
  task automatic test_fill_overflow();
    logic [31:0]   fill_value;
    deq_pkg::req_t kind;
    for (int i = 0; i < DQ_DEPTH; i++) begin
      case (i)
        0:       fill_value = 32'h8000_0000;
        1:       fill_value = 32'h7FFF_FFFF;
        2:       fill_value = 32'h0000_0000;
        3:       fill_value = 32'hFFFF_FFFF;
        4:       fill_value = 32'hAAAA_AAAA;
        5:       fill_value = 32'h5555_5555;
        default: fill_value = $urandom;
      endcase
      if (i[0]) begin
        kind = deq_pkg::REQ_PUSH_FRONT;
      end else begin
        kind = deq_pkg::REQ_PUSH_BACK;
      end
      issue_request(kind, fill_value);
    end
    issue_request(deq_pkg::REQ_PUSH_BACK, 32'hDEAD_0001);
    issue_request(deq_pkg::REQ_PUSH_FRONT, 32'hDEAD_0002);
  endtask

  // Random walk with a changing push bias so the deque swings between empty and full
  task automatic test_random_walk(int unsigned n_items);
    int unsigned   push_pct;
    deq_pkg::req_t kind;
    push_pct = 50;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      // long stretch with no gaps on either side
      gaps_on <= !(i >= 400 && i < 650);
      if ($urandom_range(99) < push_pct) begin
        if ($urandom_range(1) == 1) begin
          kind = deq_pkg::REQ_PUSH_FRONT;
        end else begin
          kind = deq_pkg::REQ_PUSH_BACK;
        end
      end else begin
        if ($urandom_range(1) == 1) begin
          kind = deq_pkg::REQ_POP_FRONT;
        end else begin
          kind = deq_pkg::REQ_POP_BACK;
        end
      end
      issue_request(kind, $urandom);
    end
    gaps_on <= 1'b1;
  endtask

  // Result side stalls
  always @(posedge clk) begin
    m_tready <= !gaps_on || ($urandom_range(99) >= STALL_PCT);
  end

  // Result checker and watchdog
  always @(posedge clk) begin : result_check
    deq_result_t want;
    deq_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = deq_result_t'(m_tdata[67:0]);
      if (pend_wr == pend_rd) begin
        note_mismatch("result with no request pending", '0, m_tdata[31:0]);
      end else begin
        want = pend_store[pend_rd % PEND_DEPTH];
        pend_rd++;
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("front_value", want.front_value, got.front_value);
        check_field("back_value", want.back_value, got.back_value);
        check_field("empty flag", 32'(want.empty_flag), 32'(got.empty_flag));
        check_field("full flag", 32'(want.full_flag), 32'(got.full_flag));
        check_field("pad bits", 32'h0, 32'(m_tdata[71:68]));
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Timeout after %0d cycles with no transfer", WDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_edges();
    test_fill_overflow();
    test_random_walk(1000);

    // drop valid at the edge that took the last request
    s_tvalid <= 1'b0;
    while (pend_wr != pend_rd) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d requests; %0d pushes refused when full, %0d pops refused when empty,",
             request_count, full_rejects, empty_rejects);
    $display("deque held its full capacity after %0d requests", full_reached);
    if (mismatch_count == 0 && pend_wr == pend_rd) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/deq_pkg.sv
hw/rtl/deq_cell.sv
hw/rtl/deq_chain.sv
hw/rtl/double_ended_queue_top.sv
test/double_ended_queue_top_test.sv
